// ===== rtl/htcsa_pkg.sv =====
// Shared types, constants and codes for the hybrid TDMA/CSMA slot access block.
package htcsa_pkg;

    // Default width of the time arithmetic
    localparam int TIME_BITS_DEF = 32;

    // Field widths
    localparam int NOW_W     = 32;
    localparam int RAND_W    = 16;
    localparam int BACKOFF_W = 16;
    localparam int PROD_W    = 20;   // my_slot (8) times slot_ticks (12)

    // Configuration register indexes (paddr[4:2])
    localparam logic [2:0] REG_MY_SLOT       = 3'd0;
    localparam logic [2:0] REG_SLOT_TICKS    = 3'd1;
    localparam logic [2:0] REG_FRAME_TICKS   = 3'd2;
    localparam logic [2:0] REG_GUARD_TICKS   = 3'd3;
    localparam logic [2:0] REG_PRE_GUARD     = 3'd4;
    localparam logic [2:0] REG_BACKOFF_LIMIT = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_MY_SLOT       = 8'd0;
    localparam logic [11:0] RST_SLOT_TICKS    = 12'd10;
    localparam logic [15:0] RST_FRAME_TICKS   = 16'd60;
    localparam logic [7:0]  RST_GUARD_TICKS   = 8'd1;
    localparam logic [7:0]  RST_PRE_GUARD     = 8'd1;
    localparam logic [15:0] RST_BACKOFF_LIMIT = 16'd512;

    // Result outcome codes
    typedef enum logic [2:0] {
        OUT_IDLE      = 3'd0,
        OUT_SLOT_SEND = 3'd1,
        OUT_CSMA_SEND = 3'd2,
        OUT_CSMA_BUSY = 3'd3,
        OUT_WAITED    = 3'd4,
        OUT_QUEUED    = 3'd5,
        OUT_QUEUE_ERR = 3'd6
    } t_outcome;

    // Serial modulo unit control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/htcsa_mod.sv =====
// Serial restoring modulo unit: one dividend bit per cycle, 16-bit divisor.
module htcsa_mod #(
    parameter int TIME_BITS = htcsa_pkg::TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  htcsa_pkg::t_div_ctl     i_ctl,
    input  logic [TIME_BITS-1:0]    i_dividend,
    input  logic [15:0]             i_divisor,
    output htcsa_pkg::t_div_sts     o_sts,
    output logic [15:0]             o_rem
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TIME_BITS-1:0] r_dvd;
    logic [15:0]          r_rem;
    logic [15:0]          r_dsr;

    logic [16:0] w_trial;
    logic        w_ge;
    logic [15:0] w_rem_nxt;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        w_trial   = {r_rem, r_dvd[TIME_BITS-1]};
        w_ge      = (w_trial >= {1'b0, r_dsr});
        w_rem_nxt = w_ge ? 16'(w_trial - {1'b0, r_dsr}) : w_trial[15:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_BITS-2:0], 1'b0};
            r_rem <= w_rem_nxt;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

`ifndef ASSERT_OFF
    // A finished remainder is always below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("modulo remainder not below divisor");
`endif

endmodule

// ===== rtl/hybrid_tdma_csma_slot_access.sv =====
// Top level: slot access decision sequencer, configuration registers and result register.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------------------------
//  in       | to block  | i_in_valid / o_in_ready    | action, now, chan_idle, random, ok
//  out      | from block| o_out_valid / i_out_ready  | outcome, transmit, backoff, rearm, repl
//  apb      | to block  | psel/penable, pready = 1   | six configuration registers
//
// A queue event or an unarmed timer event goes from idle to the done state, which loads
// the result register once it is free. An armed timer event passes the time modulo, slot
// and decide states (serial modulo unit, one time bit per cycle); a backoff draw reruns it.
// o_in_ready is high only while the sequencer is idle; a result held in the output
// register does not block the next word until that word's own result is ready.
// Reset is synchronous: pending and armed clear, registers take their defaults.
module hybrid_tdma_csma_slot_access #(
    parameter int TIME_BITS = htcsa_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_now,
    input  logic        i_chan_idle,
    input  logic [15:0] i_random_value,
    input  logic        i_alloc_ok,
    // result word
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_outcome,
    output logic        o_transmit,
    output logic [15:0] o_backoff_ticks,
    output logic        o_rearm_timer,
    output logic        o_replaced_old,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MODT,
        S_SLOT,
        S_DECIDE,
        S_MODR,
        S_DONE
    } t_state;

    // Configuration registers
    logic [7:0]  r_my_slot;
    logic [11:0] r_slot_ticks;
    logic [15:0] r_frame_ticks;
    logic [7:0]  r_guard_ticks;
    logic [7:0]  r_pre_guard;
    logic [15:0] r_backoff_limit;

    // Sequencer and block state
    t_state               r_state;
    logic                 r_pending;
    logic                 r_armed;
    logic [TIME_BITS-1:0] r_time;
    logic                 r_clear;
    logic [15:0]          r_rnd;
    logic [htcsa_pkg::PROD_W-1:0] r_prod;
    logic [TIME_BITS-1:0] r_sstart;
    logic [TIME_BITS-1:0] r_send;
    logic [TIME_BITS-1:0] r_pstart;

    // Staged result and output register
    htcsa_pkg::t_outcome  r_res_outcome;
    logic                 r_res_tx;
    logic [15:0]          r_res_backoff;
    logic                 r_res_rearm;
    logic                 r_res_repl;
    logic                 r_out_valid;
    htcsa_pkg::t_outcome  r_out_outcome;
    logic                 r_out_tx;
    logic [15:0]          r_out_backoff;
    logic                 r_out_rearm;
    logic                 r_out_repl;

    // Modulo unit hookup
    htcsa_pkg::t_div_ctl  div_ctl;
    htcsa_pkg::t_div_sts  div_sts;
    logic [TIME_BITS-1:0] div_dividend;
    logic [15:0]          div_divisor;
    logic [15:0]          div_rem;

    logic w_cfg_wr;
    logic w_accept;
    logic w_outside;
    logic w_waited;
    logic w_out_free;

    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign pready     = 1'b1;

    // Slot window compares
    assign w_outside = (r_time < r_sstart) || (r_time > r_send);
    assign w_waited  = (r_time >= r_pstart) && (r_time < r_send);

    // Start the modulo unit on the time (idle) or on the random value (decide)
    always_comb begin
        div_ctl.start = 1'b0;
        div_dividend  = TIME_BITS'(i_now);
        div_divisor   = (r_frame_ticks == 16'd0) ? 16'd1 : r_frame_ticks;
        if (r_state == S_IDLE) begin
            div_ctl.start = w_accept && !i_action && r_armed;
        end else if (r_state == S_DECIDE) begin
            div_ctl.start = w_outside && r_pending;
            div_dividend  = TIME_BITS'(r_rnd);
            div_divisor   = (r_backoff_limit == 16'd0) ? 16'd1 : r_backoff_limit;
        end
    end

    htcsa_mod #(
        .TIME_BITS (TIME_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_sts      (div_sts),
        .o_rem      (div_rem)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_slot       <= htcsa_pkg::RST_MY_SLOT;
            r_slot_ticks    <= htcsa_pkg::RST_SLOT_TICKS;
            r_frame_ticks   <= htcsa_pkg::RST_FRAME_TICKS;
            r_guard_ticks   <= htcsa_pkg::RST_GUARD_TICKS;
            r_pre_guard     <= htcsa_pkg::RST_PRE_GUARD;
            r_backoff_limit <= htcsa_pkg::RST_BACKOFF_LIMIT;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                htcsa_pkg::REG_MY_SLOT:       r_my_slot       <= pwdata[7:0];
                htcsa_pkg::REG_SLOT_TICKS:    r_slot_ticks    <= pwdata[11:0];
                htcsa_pkg::REG_FRAME_TICKS:   r_frame_ticks   <= pwdata[15:0];
                htcsa_pkg::REG_GUARD_TICKS:   r_guard_ticks   <= pwdata[7:0];
                htcsa_pkg::REG_PRE_GUARD:     r_pre_guard     <= pwdata[7:0];
                htcsa_pkg::REG_BACKOFF_LIMIT: r_backoff_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (paddr[4:2])
            htcsa_pkg::REG_MY_SLOT:       prdata = 32'(r_my_slot);
            htcsa_pkg::REG_SLOT_TICKS:    prdata = 32'(r_slot_ticks);
            htcsa_pkg::REG_FRAME_TICKS:   prdata = 32'(r_frame_ticks);
            htcsa_pkg::REG_GUARD_TICKS:   prdata = 32'(r_guard_ticks);
            htcsa_pkg::REG_PRE_GUARD:     prdata = 32'(r_pre_guard);
            htcsa_pkg::REG_BACKOFF_LIMIT: prdata = 32'(r_backoff_limit);
            default:                      prdata = 32'd0;
        endcase
    end

    // Sequencer: state, block state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads now
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_time        <= TIME_BITS'(i_now);
                        r_clear       <= i_chan_idle;
                        r_rnd         <= i_random_value;
                        r_prod        <= htcsa_pkg::PROD_W'(r_my_slot)
                                         * htcsa_pkg::PROD_W'(r_slot_ticks);
                        r_res_tx      <= 1'b0;
                        r_res_backoff <= '0;
                        r_res_repl    <= i_action && r_pending;
                        if (i_action) begin
                            // queue event: store pending, arm the timer once
                            r_res_outcome <= i_alloc_ok ? htcsa_pkg::OUT_QUEUED
                                                        : htcsa_pkg::OUT_QUEUE_ERR;
                            r_res_rearm   <= !r_armed;
                            r_pending     <= i_alloc_ok;
                            r_armed       <= 1'b1;
                            r_state       <= S_DONE;
                        end else if (!r_armed) begin
                            r_res_outcome <= htcsa_pkg::OUT_IDLE;
                            r_res_rearm   <= 1'b0;
                            r_state       <= S_DONE;
                        end else begin
                            r_res_rearm   <= 1'b1;
                            r_state       <= S_MODT;
                        end
                    end
                end
                S_MODT: begin
                    // slot start = now - (now mod frame) + my_slot * slot_ticks
                    if (div_sts.done) begin
                        r_sstart <= r_time - TIME_BITS'(div_rem) + TIME_BITS'(r_prod);
                        r_state  <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    r_send   <= r_sstart + TIME_BITS'(r_slot_ticks)
                                - TIME_BITS'(r_guard_ticks);
                    r_pstart <= r_sstart - TIME_BITS'(r_pre_guard);
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_outside) begin
                        if (r_pending) begin
                            r_state <= S_MODR;
                        end else begin
                            r_res_outcome <= w_waited ? htcsa_pkg::OUT_WAITED
                                                      : htcsa_pkg::OUT_IDLE;
                            r_state       <= S_DONE;
                        end
                    end else begin
                        if (r_pending) begin
                            r_res_outcome <= htcsa_pkg::OUT_SLOT_SEND;
                            r_res_tx      <= 1'b1;
                            r_pending     <= 1'b0;
                        end else begin
                            r_res_outcome <= htcsa_pkg::OUT_IDLE;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_MODR: begin
                    // backoff drawn; send if the channel is clear
                    if (div_sts.done) begin
                        r_res_backoff <= div_rem;
                        if (r_clear) begin
                            r_res_outcome <= htcsa_pkg::OUT_CSMA_SEND;
                            r_res_tx      <= 1'b1;
                            r_pending     <= 1'b0;
                        end else begin
                            r_res_outcome <= htcsa_pkg::OUT_CSMA_BUSY;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_outcome <= r_res_outcome;
                        r_out_tx      <= r_res_tx;
                        r_out_backoff <= r_res_backoff;
                        r_out_rearm   <= r_res_rearm;
                        r_out_repl    <= r_res_repl;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_outcome       = r_out_outcome;
    assign o_transmit      = r_out_tx;
    assign o_backoff_ticks = r_out_backoff;
    assign o_rearm_timer   = r_out_rearm;
    assign o_replaced_old  = r_out_repl;

`ifndef ASSERT_OFF
    // The modulo unit is never busy while a new word may enter
    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_sts.busy)
        else $error("modulo unit busy while sequencer idle");

    // Once armed, the slot timer stays armed
    a_armed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |=> r_armed)
        else $error("timer armed flag fell");

    // Transmit goes with exactly the two send outcomes
    a_tx_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_transmit == ((o_outcome == htcsa_pkg::OUT_SLOT_SEND) ||
                                        (o_outcome == htcsa_pkg::OUT_CSMA_SEND))))
        else $error("transmit flag disagrees with outcome");

    // A backoff shows up only on a CSMA outcome
    a_backoff_csma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_backoff_ticks != 16'd0)) |->
            ((o_outcome == htcsa_pkg::OUT_CSMA_SEND) ||
             (o_outcome == htcsa_pkg::OUT_CSMA_BUSY)))
        else $error("backoff on a non-CSMA outcome");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the hybrid TDMA/CSMA slot access block.
`timescale 1ns / 1ps

module testbench;

    // Event codes carried on i_action
    localparam bit ACT_TIMER = 1'b0;
    localparam bit ACT_QUEUE = 1'b1;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned RANDOM_WORDS = 65;
    localparam int unsigned RANDOM_PHASES = 8;

    typedef struct packed {
        bit        action;
        bit [31:0] now;
        bit        chan_idle;
        bit [15:0] random_value;
        bit        alloc_ok;
    } t_access_word;

    typedef struct packed {
        htcsa_pkg::t_outcome outcome;
        bit        transmit;
        bit [15:0] backoff_ticks;
        bit        rearm_timer;
        bit        replaced_old;
    } t_access_result;

    // Mirror of the slot access decision: configuration, pending/armed state
    // and the queue of decisions still owed by the block.
    class t_access_scoreboard;
        bit [7:0]  my_slot;
        bit [11:0] slot_ticks;
        bit [15:0] frame_ticks;
        bit [7:0]  guard_ticks;
        bit [7:0]  pre_guard_ticks;
        bit [15:0] backoff_limit;
        bit        packet_pending;
        bit        timer_armed;
        t_access_result owed_decisions[$];
        int unsigned    mismatches;

        function new();
            my_slot         = htcsa_pkg::RST_MY_SLOT;
            slot_ticks      = htcsa_pkg::RST_SLOT_TICKS;
            frame_ticks     = htcsa_pkg::RST_FRAME_TICKS;
            guard_ticks     = htcsa_pkg::RST_GUARD_TICKS;
            pre_guard_ticks = htcsa_pkg::RST_PRE_GUARD;
            backoff_limit   = htcsa_pkg::RST_BACKOFF_LIMIT;
            packet_pending  = 1'b0;
            timer_armed     = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                htcsa_pkg::REG_MY_SLOT:       my_slot         = value[7:0];
                htcsa_pkg::REG_SLOT_TICKS:    slot_ticks      = value[11:0];
                htcsa_pkg::REG_FRAME_TICKS:   frame_ticks     = value[15:0];
                htcsa_pkg::REG_GUARD_TICKS:   guard_ticks     = value[7:0];
                htcsa_pkg::REG_PRE_GUARD:     pre_guard_ticks = value[7:0];
                htcsa_pkg::REG_BACKOFF_LIMIT: backoff_limit   = value[15:0];
                default: ;
            endcase
        endfunction

        // Work out the access decision for one word and advance the state
        function t_access_result decide_access(t_access_word w);
            t_access_result r;
            bit [31:0] frame, fstart, sstart, slot_end, pstart;
            bit [15:0] lim;
            bit        outside;
            r = '0;
            r.outcome = htcsa_pkg::OUT_IDLE;
            if (w.action == ACT_QUEUE) begin
                r.replaced_old = packet_pending;
                r.outcome = w.alloc_ok ? htcsa_pkg::OUT_QUEUED : htcsa_pkg::OUT_QUEUE_ERR;
                packet_pending = w.alloc_ok;
                if (!timer_armed) begin
                    timer_armed = 1'b1;
                    r.rearm_timer = 1'b1;
                end
                return r;
            end
            if (!timer_armed)
                return r;

            // locate frame, own slot and pre-guard window, wrapping at 32 bits
            r.rearm_timer = 1'b1;
            frame    = (frame_ticks == 0) ? 32'd1 : 32'(frame_ticks);
            fstart   = w.now - (w.now % frame);
            sstart   = fstart + 32'(my_slot) * 32'(slot_ticks);
            slot_end = sstart + 32'(slot_ticks) - 32'(guard_ticks);
            pstart   = sstart - 32'(pre_guard_ticks);
            outside  = (w.now < sstart) || (w.now > slot_end);

            if (outside && packet_pending) begin
                lim = (backoff_limit == 0) ? 16'd1 : backoff_limit;
                r.backoff_ticks = w.random_value % lim;
                if (w.chan_idle) begin
                    packet_pending = 1'b0;
                    r.outcome  = htcsa_pkg::OUT_CSMA_SEND;
                    r.transmit = 1'b1;
                end else begin
                    r.outcome = htcsa_pkg::OUT_CSMA_BUSY;
                end
            end else if (outside) begin
                if (w.now >= pstart && w.now < slot_end)
                    r.outcome = htcsa_pkg::OUT_WAITED;
            end else if (packet_pending) begin
                packet_pending = 1'b0;
                r.outcome  = htcsa_pkg::OUT_SLOT_SEND;
                r.transmit = 1'b1;
            end
            return r;
        endfunction

        function void note_word(t_access_word w);
            owed_decisions.push_back(decide_access(w));
        endfunction

        task report(string what);
            if (mismatches < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(t_access_result got);
            t_access_result want;
            if (owed_decisions.size() == 0) begin
                report("result word with no decision owed");
                return;
            end
            want = owed_decisions.pop_front();
            if (got.outcome != want.outcome)
                report($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
            if (got.transmit != want.transmit)
                report($sformatf("transmit %0d, want %0d", got.transmit, want.transmit));
            if (got.backoff_ticks != want.backoff_ticks)
                report($sformatf("backoff_ticks %0d, want %0d",
                                 got.backoff_ticks, want.backoff_ticks));
            if (got.rearm_timer != want.rearm_timer)
                report($sformatf("rearm_timer %0d, want %0d",
                                 got.rearm_timer, want.rearm_timer));
            if (got.replaced_old != want.replaced_old)
                report($sformatf("replaced_old %0d, want %0d",
                                 got.replaced_old, want.replaced_old));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [31:0] i_now;
    logic        i_chan_idle;
    logic [15:0] i_random_value;
    logic        i_alloc_ok;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_outcome;
    logic        o_transmit;
    logic [15:0] o_backoff_ticks;
    logic        o_rearm_timer;
    logic        o_replaced_old;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_access_scoreboard sb;
    bit                 calm;
    int unsigned        cycle_count = 0;

    hybrid_tdma_csma_slot_access u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_now           (i_now),
        .i_chan_idle     (i_chan_idle),
        .i_random_value  (i_random_value),
        .i_alloc_ok      (i_alloc_ok),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_outcome       (o_outcome),
        .o_transmit      (o_transmit),
        .o_backoff_ticks (o_backoff_ticks),
        .o_rearm_timer   (o_rearm_timer),
        .o_replaced_old  (o_replaced_old),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic t_access_word mk_word(bit action, bit [31:0] now, bit clear,
                                             bit [15:0] rnd, bit ok);
        t_access_word w;
        w.action        = action;
        w.now           = now;
        w.chan_idle     = clear;
        w.random_value  = rnd;
        w.alloc_ok      = ok;
        return w;
    endfunction

    // Random word, with timer times steered to the slot edges and pre-guard window
    function automatic t_access_word make_word();
        t_access_word w;
        bit [31:0] frame, fstart, sstart;
        w = mk_word(($urandom_range(0, 99) < 28) ? ACT_QUEUE : ACT_TIMER, $urandom,
                    $urandom_range(0, 1), $urandom, $urandom_range(0, 9) != 0);
        if (w.action == ACT_TIMER) begin
            frame  = (sb.frame_ticks == 0) ? 32'd1 : 32'(sb.frame_ticks);
            fstart = w.now - (w.now % frame);
            sstart = fstart + 32'(sb.my_slot) * 32'(sb.slot_ticks);
            case ($urandom_range(0, 5))
                1: w.now = sstart + $urandom_range(0, sb.slot_ticks);
                2: w.now = sstart - $urandom_range(0, sb.pre_guard_ticks + 2);
                3: w.now = sstart + sb.slot_ticks - sb.guard_ticks
                           + $urandom_range(0, 2) - 1;
                4: w.now = fstart + $urandom_range(0, frame - 1);
                5: w.now = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 255)
                                                : 32'($urandom_range(0, 255));
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic bit [31:0] pick_value(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Offer one word; valid stays high across back-to-back words
    task automatic send_word(t_access_word w);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= w.action;
        i_now           <= w.now;
        i_chan_idle     <= w.chan_idle;
        i_random_value  <= w.random_value;
        i_alloc_ok      <= w.alloc_ok;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    // Hold off the sender until every owed decision is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.owed_decisions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(bit [31:0] slot_idx, bit [31:0] slot_len, bit [31:0] frame_len,
                             bit [31:0] guard, bit [31:0] pre_guard, bit [31:0] limit);
        reg_write(htcsa_pkg::REG_MY_SLOT, slot_idx);
        reg_write(htcsa_pkg::REG_SLOT_TICKS, slot_len);
        reg_write(htcsa_pkg::REG_FRAME_TICKS, frame_len);
        reg_write(htcsa_pkg::REG_GUARD_TICKS, guard);
        reg_write(htcsa_pkg::REG_PRE_GUARD, pre_guard);
        reg_write(htcsa_pkg::REG_BACKOFF_LIMIT, limit);
    endtask

    // Accept result words and hand them to the scoreboard
    task automatic collect_results();
        t_access_result got;
        int unsigned    gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.outcome       = htcsa_pkg::t_outcome'(o_outcome);
            got.transmit      = o_transmit;
            got.backoff_ticks = o_backoff_ticks;
            got.rearm_timer   = o_rearm_timer;
            got.replaced_old  = o_replaced_old;
            sb.check_result(got);
        end
    endtask

    initial begin
        sb              = new();
        calm            = 1'b0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_TIMER;
        i_now           <= '0;
        i_chan_idle     <= 1'b0;
        i_random_value  <= '0;
        i_alloc_ok      <= 1'b0;
        i_out_ready     <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            collect_results();
        join_none

        // Reset settings: unarmed timer, queue error, replacement, slot and CSMA sends
        send_word(mk_word(ACT_TIMER, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'd0, 1'b0, 16'h0000, 1'b0));
        send_word(mk_word(ACT_QUEUE, 32'd7, 1'b0, 16'h0001, 1'b0));
        send_word(mk_word(ACT_QUEUE, 32'd0, 1'b1, 16'h0000, 1'b1));
        send_word(mk_word(ACT_QUEUE, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'd125, 1'b0, 16'h1234, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'd125, 1'b1, 16'h1234, 1'b1));
        send_word(mk_word(ACT_QUEUE, 32'd0, 1'b0, 16'h0000, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'd150, 1'b0, 16'hFFFF, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'd150, 1'b1, 16'h0200, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'hFFFF_FFFF, 1'b0, 16'h5555, 1'b1));
        send_word(mk_word(ACT_QUEUE, 32'd3, 1'b1, 16'h0000, 1'b1));
        send_word(mk_word(ACT_QUEUE, 32'd3, 1'b1, 16'h0000, 1'b0));
        drain();

        // Own slot 2 with a pre-guard window and a zero backoff limit
        write_all(2, 10, 60, 1, 3, 0);
        send_word(mk_word(ACT_TIMER, 32'd78, 1'b0, 16'h0000, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'd90, 1'b0, 16'h0000, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'd89, 1'b1, 16'h0000, 1'b0));
        send_word(mk_word(ACT_QUEUE, 32'd0, 1'b0, 16'h0000, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'd70, 1'b0, 16'hABCD, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'd80, 1'b0, 16'hABCD, 1'b0));
        drain();

        // Zero frame length, widest slot, guard and pre-guard, top backoff limit
        write_all(255, 4095, 0, 255, 255, 65535);
        send_word(mk_word(ACT_QUEUE, 32'd0, 1'b0, 16'h0000, 1'b1));
        send_word(mk_word(ACT_TIMER, 32'h1234_5678, 1'b1, 16'hFFFF, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'hFFFF_FFFF - 32'd1000, 1'b0, 16'h0000, 1'b0));
        send_word(mk_word(ACT_TIMER, 32'hFFFF_FFFF, 1'b1, 16'h7FFF, 1'b1));
        drain();

        // Random phases over a spread of settings
        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == 3) || (p == 6);
            case (p)
                0: write_all(0, 1, 0, 0, 0, 0);
                1: write_all(255, 4095, 65535, 255, 255, 65535);
                2: write_all($urandom_range(0, 5), 10, 60, 1, $urandom_range(0, 12),
                             $urandom_range(1, 600));
                default: write_all(pick_value(0, 255), pick_value(1, 4095),
                                   pick_value(0, 65535), pick_value(0, 255),
                                   pick_value(0, 255), pick_value(0, 65535));
            endcase
            for (int unsigned n = 0; n < RANDOM_WORDS; n++)
                send_word(make_word());
            drain();
        end
        calm = 1'b0;

        // Let any stray word surface before the verdict
        repeat (80) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed_decisions.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
